>>> rtl/core/tdpc_pkg.sv
// Package for the thermal derating PI controller: item types, command and
// status structs, state encoding, constants and shared arithmetic helpers.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package tdpc_pkg;

  localparam int TempW  = 7;
  localparam int CurW   = 14;
  localparam int StateW = 16;
  localparam int WideW  = 21;
  localparam int CfgIdxW = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_HOLD_TEMP,
    REG_RELEASE_TEMP,
    REG_SHUTDOWN_TEMP,
    REG_TURBO_DIS_TEMP,
    REG_MIN_CURRENT,
    REG_HOLD_CURRENT,
    REG_FOLDBACK_CURRENT,
    REG_TURBO_FAST_CURRENT
  } cfg_reg_t;

  // Fault codes.
  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_THERMAL = 2'd1;
  localparam logic [1:0] FAULT_SENSOR  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [TempW-1:0] RST_HOLD_TEMP      = 7'd45;
  localparam logic [TempW-1:0] RST_RELEASE_TEMP   = 7'd40;
  localparam logic [TempW-1:0] RST_SHUTDOWN_TEMP  = 7'd65;
  localparam logic [TempW-1:0] RST_TURBO_DIS_TEMP = 7'd50;
  localparam logic [CurW-1:0]  RST_MIN_CURRENT    = 14'd390;
  localparam logic [CurW-1:0]  RST_HOLD_CURRENT   = 14'd750;
  localparam logic [CurW-1:0]  RST_FOLDBACK_CURRENT   = 14'd500;
  localparam logic [CurW-1:0]  RST_TURBO_FAST_CURRENT = 14'd2850;

  // Loop constants.
  localparam logic [6:0]  LOCK_SHORT   = 7'd24;
  localparam logic [6:0]  LOCK_LONG    = 7'd60;
  localparam int          ItgFullScale = 2500 * 12;
  localparam int          CommitLevel  = 120 * 8;
  localparam logic [16:0] RECIP12      = 17'd43691;
  localparam int          Recip12Shift = 19;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_FLAGS,
    S_LOOP_A,
    S_LOOP_B,
    S_LOOP_C,
    S_LOOP_D,
    S_DIV,
    S_LIMIT,
    S_OUT
  } state_t;

  // Kind of update taken when the temperature is above the hold point.
  typedef enum logic [1:0] {
    BR_NONE,
    BR_TURBO,
    BR_PF
  } hot_br_t;

  typedef struct packed {
    logic             kind;
    logic signed [7:0] temperature;
    logic             sensor_ok;
    logic             output_enabled;
    logic             pause_derating;
    logic             mode_needs_derating;
    logic             is_turbo_mode;
    logic [CurW-1:0]  requested_current;
    logic [CurW-1:0]  present_current;
    logic [CurW-1:0]  last_gear_current;
    logic [CurW-1:0]  new_gear_current;
  } in_item_t;

  typedef struct packed {
    logic [CurW-1:0] current_limit;
    logic            step_down_active;
    logic            force_leave_turbo;
    logic            disable_turbo;
    logic [1:0]      fault;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic flags;
    logic loop_a;
    logic loop_b;
    logic loop_c;
    logic loop_d;
    logic div;
    logic limit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gear;
    logic run;
  } status_t;

  // Saturate a wide signed value to the 16-bit state range.
  function automatic logic signed [StateW-1:0] sat16(input logic signed [WideW-1:0] v);
    logic signed [StateW-1:0] r;
    if (v > 21'sd32767) begin
      r = 16'sd32767;
    end else if (v < -21'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[StateW-1:0];
    end
    return r;
  endfunction

  // Hysteresis: set above high, clear below low, else hold.
  function automatic logic hyst(input logic held, input logic signed [9:0] t,
                                input logic signed [9:0] high,
                                input logic signed [9:0] low);
    logic r;
    if (t > high) begin
      r = 1'b1;
    end else if (t < low) begin
      r = 1'b0;
    end else begin
      r = held;
    end
    return r;
  endfunction

  // Signed division by 12, truncating toward zero, by reciprocal multiply.
  function automatic logic signed [12:0] div12(input logic signed [StateW-1:0] v);
    logic [16:0] mag;
    logic [33:0] prod;
    logic [11:0] q;
    logic signed [12:0] r;
    mag  = v[StateW-1] ? 17'(-$signed({v[StateW-1], v})) : {1'b0, v};
    prod = mag * RECIP12;
    q    = prod[Recip12Shift +: 12];
    r    = v[StateW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    return r;
  endfunction

  // Proportional factor base: present current over 1000 or over 1300.
  function automatic logic [4:0] pf_base(input logic [CurW-1:0] cur, input logic turbo);
    logic [4:0] n;
    n = 5'd0;
    for (int k = 1; k <= 16; k++) begin
      if (turbo && ({1'b0, cur} >= 15'(k * 1000))) begin
        n = n + 5'd1;
      end
      if (!turbo && (k <= 12) && ({1'b0, cur} >= 15'(k * 1300))) begin
        n = n + 5'd1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/tdpc_if.sv
// Handshake channel interfaces of the thermal derating PI controller:
// input items, result items and configuration writes. Uses tdpc_pkg.
`default_nettype none

interface tdpc_in_if;
  logic                valid;
  logic                ready;
  tdpc_pkg::in_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface tdpc_out_if;
  logic                valid;
  logic                ready;
  tdpc_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface tdpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tdpc_pkg::CfgIdxW-1:0]    index;
  logic [tdpc_pkg::CurW-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tdpc_datapath.sv
// Datapath of the thermal derating PI controller: configuration registers,
// loop state, the shared divide-by-12 unit and the result register.
// Uses tdpc_pkg; driven by tdpc_ctrl commands.
`default_nettype none

module tdpc_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tdpc_pkg::cmd_t        cmd,
  output tdpc_pkg::status_t          status,
  input  wire tdpc_pkg::in_item_t    item_d,
  output tdpc_pkg::out_item_t        result_q,
  input  wire logic                  cfg_we,
  input  wire logic [tdpc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [tdpc_pkg::CurW-1:0]    cfg_data
);

  // Configuration registers.
  logic [tdpc_pkg::TempW-1:0] hold_t, rel_t, shut_t, tdis_t;
  logic [tdpc_pkg::CurW-1:0]  min_c, hold_c, fb_c, tfast_c;

  // Captured item and loop state.
  tdpc_pkg::in_item_t          it;
  logic signed [15:0]          integrator, prop;
  logic [6:0]                  lock;
  logic                        near, sdf, lim_act, shut_f, leave_f, dis_f;
  logic [1:0]                  fault_code;

  // Per-tick working registers.
  logic                        mode_hot, mode_cold, fast, lock_zero;
  logic [7:0]                  err;
  tdpc_pkg::hot_br_t           br;
  logic [4:0]                  pf;
  logic [11:0]                 pf2;
  logic signed [12:0]          q12;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_t  <= tdpc_pkg::RST_HOLD_TEMP;
      rel_t   <= tdpc_pkg::RST_RELEASE_TEMP;
      shut_t  <= tdpc_pkg::RST_SHUTDOWN_TEMP;
      tdis_t  <= tdpc_pkg::RST_TURBO_DIS_TEMP;
      min_c   <= tdpc_pkg::RST_MIN_CURRENT;
      hold_c  <= tdpc_pkg::RST_HOLD_CURRENT;
      fb_c    <= tdpc_pkg::RST_FOLDBACK_CURRENT;
      tfast_c <= tdpc_pkg::RST_TURBO_FAST_CURRENT;
    end else if (cfg_we) begin
      case (tdpc_pkg::cfg_reg_t'(cfg_index))
        tdpc_pkg::REG_HOLD_TEMP:          hold_t  <= cfg_data[tdpc_pkg::TempW-1:0];
        tdpc_pkg::REG_RELEASE_TEMP:       rel_t   <= cfg_data[tdpc_pkg::TempW-1:0];
        tdpc_pkg::REG_SHUTDOWN_TEMP:      shut_t  <= cfg_data[tdpc_pkg::TempW-1:0];
        tdpc_pkg::REG_TURBO_DIS_TEMP:     tdis_t  <= cfg_data[tdpc_pkg::TempW-1:0];
        tdpc_pkg::REG_MIN_CURRENT:        min_c   <= cfg_data;
        tdpc_pkg::REG_HOLD_CURRENT:       hold_c  <= cfg_data;
        tdpc_pkg::REG_FOLDBACK_CURRENT:   fb_c    <= cfg_data;
        tdpc_pkg::REG_TURBO_FAST_CURRENT: tfast_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sign-extended temperatures and thresholds.
  logic signed [9:0] tw, hold_s, rel_s, shut_s, tdis_s;
  assign tw     = {{2{it.temperature[7]}}, it.temperature};
  assign hold_s = $signed({3'b000, hold_t});
  assign rel_s  = $signed({3'b000, rel_t});
  assign shut_s = $signed({3'b000, shut_t});
  assign tdis_s = $signed({3'b000, tdis_t});

  logic signed [15:0] req_s, min_s, cur_s, reqmin;
  assign req_s  = $signed({2'b00, it.requested_current});
  assign min_s  = $signed({2'b00, min_c});
  assign cur_s  = $signed({2'b00, it.present_current});
  assign reqmin = req_s - min_s;

  // Hysteresis flags and limiter activation for a tick.
  logic leave_n, dis_n, shut_n, lim_n;
  always_comb begin
    leave_n = tdpc_pkg::hyst(leave_f, tw, shut_s - 10'sd10, tdis_s - 10'sd10);
    dis_n   = tdpc_pkg::hyst(dis_f, tw, tdis_s, tdis_s - 10'sd10);
    shut_n  = tdpc_pkg::hyst(shut_f, tw, shut_s, hold_s - 10'sd5);
    if (!it.mode_needs_derating) begin
      lim_n = 1'b0;
    end else if (tdpc_pkg::hyst(lim_act, tw, hold_s, rel_s)) begin
      lim_n = 1'b1;
    end else if ((prop == 16'sd0) && (integrator < 16'sd0)) begin
      lim_n = 1'b0;
    end else begin
      lim_n = lim_act;
    end
  end

  // First loop stage: classify the temperature error and pick the branch.
  logic [tdpc_pkg::CurW-1:0] hold_i;
  logic signed [9:0]         err_hot, err_cold;
  logic                      hot, cold, fast_a, near_set, cold_itg;
  tdpc_pkg::hot_br_t         br_a;
  always_comb begin
    hold_i   = near ? fb_c : hold_c;
    hot      = tw > hold_s;
    cold     = tw < hold_s;
    err_hot  = tw - hold_s;
    err_cold = hold_s - tw;
    if (it.is_turbo_mode && (it.present_current > tfast_c)) begin
      br_a = tdpc_pkg::BR_TURBO;
    end else if (err_hot > 10'sd2) begin
      br_a = tdpc_pkg::BR_PF;
    end else begin
      br_a = tdpc_pkg::BR_NONE;
    end
    cold_itg = (err_cold > 10'sd4) ||
               !(cur_s > ($signed({2'b00, hold_i}) - 16'sd200));
    fast_a   = hot ? (it.present_current < hold_i) : cold_itg;
    near_set = hot && (tw > (shut_s - 10'sd13));
  end

  // Third loop stage: proportional term update.
  logic signed [20:0] p_w, prod_w;
  logic signed [15:0] p_commit, p_c;
  logic signed [15:0] i_commit, i_c;
  logic [16:0]        abs_i;
  logic               commit_ok;
  always_comb begin
    p_w       = 21'(prop);
    abs_i     = integrator[15] ? 17'(-$signed({integrator[15], integrator}))
                               : {1'b0, integrator};
    commit_ok = abs_i >= 17'(tdpc_pkg::CommitLevel);
    p_commit  = commit_ok ? tdpc_pkg::sat16(p_w + 21'(q12)) : prop;
    i_commit  = commit_ok ? 16'sd0 : integrator;
    prod_w    = $signed({9'd0, pf2}) * $signed({13'd0, err});
    p_c       = prop;
    i_c       = integrator;
    if (mode_hot) begin
      case (br)
        tdpc_pkg::BR_TURBO: begin
          p_c = tdpc_pkg::sat16(p_w + 21'sd20 * $signed({13'd0, err}));
        end
        tdpc_pkg::BR_PF: begin
          if (fast) begin
            p_c = p_commit;
            i_c = i_commit;
          end else begin
            p_c = tdpc_pkg::sat16(p_w + prod_w);
          end
          if (p_c > reqmin) begin
            p_c = reqmin;
          end
        end
        default: ;
      endcase
    end else if (mode_cold) begin
      if (lock_zero) begin
        if (fast) begin
          p_c = p_commit;
          i_c = i_commit;
        end else begin
          if (err > 8'd1) begin
            p_c = tdpc_pkg::sat16(p_w - $signed({13'd0, err}));
          end
        end
      end
      if (p_c < 16'sd0) begin
        p_c = 16'sd0;
      end
    end
  end

  // Fourth loop stage: integrator step.
  logic signed [9:0]  d10;
  logic [8:0]         d9;
  logic [9:0]         dd;
  logic signed [15:0] i_d;
  always_comb begin
    d10 = mode_hot ? (tw - (shut_s - 10'sd18)) : ((rel_s + 10'sd5) - tw);
    d9  = d10[9] ? 9'd0 : d10[8:0];
    if ((abs_i < 17'(tdpc_pkg::ItgFullScale - int'(d9))) && fast) begin
      dd = {d9, 1'b1};
    end else begin
      dd = 10'd1;
    end
    if (mode_hot) begin
      i_d = tdpc_pkg::sat16(21'(integrator) + $signed({11'd0, dd}));
    end else begin
      i_d = tdpc_pkg::sat16(21'(integrator) - $signed({11'd0, dd}));
    end
  end

  // Limit computation.
  logic signed [17:0] r0, r1;
  logic               r_low;
  always_comb begin
    r0 = 18'(prop) + 18'(q12);
    if (r0 < 18'sd0) begin
      r0 = 18'sd0;
    end
    r1    = 18'(req_s) - r0;
    r_low = r1 < 18'(min_s);
    if (r_low) begin
      r1 = 18'(min_s);
    end
  end

  assign status.gear = it.kind;
  assign status.run  = lim_act && !it.pause_derating && it.output_enabled;

  // Loop state and item sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
      prop       <= '0;
      lock       <= '0;
      near       <= 1'b0;
      sdf        <= 1'b0;
      lim_act    <= 1'b0;
      shut_f     <= 1'b0;
      leave_f    <= 1'b0;
      dis_f      <= 1'b0;
      fault_code <= tdpc_pkg::FAULT_NONE;
    end else begin
      if (cmd.flags) begin
        if (it.kind) begin
          // Gear change: rebase the proportional term.
          if (it.mode_needs_derating &&
              (it.new_gear_current > it.last_gear_current)) begin
            prop <= $signed({2'b00, it.new_gear_current - it.last_gear_current});
          end else begin
            prop <= '0;
          end
          integrator <= '0;
        end else if (it.sensor_ok) begin
          leave_f <= leave_n;
          dis_f   <= dis_n;
          shut_f  <= shut_n;
          lim_act <= lim_n;
          if (shut_n) begin
            fault_code <= tdpc_pkg::FAULT_THERMAL;
          end else if (fault_code == tdpc_pkg::FAULT_THERMAL) begin
            fault_code <= tdpc_pkg::FAULT_NONE;
          end
        end else begin
          fault_code <= tdpc_pkg::FAULT_SENSOR;
        end
      end
      if (cmd.loop_a) begin
        if (!lim_act) begin
          near       <= 1'b0;
          integrator <= '0;
          prop       <= '0;
          sdf        <= 1'b0;
        end else if (status.run) begin
          if (hot) begin
            near <= near | near_set;
            lock <= (br_a == tdpc_pkg::BR_PF) ? tdpc_pkg::LOCK_LONG : tdpc_pkg::LOCK_SHORT;
          end else if (cold) begin
            if (lock != 7'd0) begin
              lock <= lock - 7'd1;
            end else if (near && (it.present_current > hold_c)) begin
              near <= 1'b0;
            end
          end
        end
      end
      if (cmd.loop_c) begin
        prop       <= p_c;
        integrator <= i_c;
      end
      if (cmd.loop_d && (mode_hot || mode_cold)) begin
        integrator <= i_d;
      end
      if (cmd.limit) begin
        if (!lim_act) begin
          sdf <= 1'b0;
        end else begin
          if (r_low) begin
            prop       <= reqmin;
            integrator <= '0;
          end
          if (r1 < (18'(req_s) - 18'sd150)) begin
            sdf <= 1'b1;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it <= item_d;
    end
    if (cmd.loop_a) begin
      mode_hot  <= hot;
      mode_cold <= cold;
      err       <= hot ? err_hot[7:0] : err_cold[7:0];
      fast      <= fast_a;
      br        <= br_a;
      pf        <= tdpc_pkg::pf_base(it.present_current, it.is_turbo_mode) + 5'd1;
      lock_zero <= lock == 7'd0;
    end
    if (cmd.loop_b) begin
      if (err > 8'd3) begin
        pf2 <= 12'(pf) * (12'(err) + 12'd2);
      end else begin
        pf2 <= {7'd0, pf};
      end
    end
    if (cmd.loop_b || cmd.div) begin
      q12 <= tdpc_pkg::div12(integrator);
    end
    if (cmd.limit) begin
      result_q.current_limit     <= lim_act ? r1[13:0] : it.requested_current;
      result_q.step_down_active  <= lim_act && (sdf || (r1 < (18'(req_s) - 18'sd150)));
      result_q.force_leave_turbo <= leave_f;
      result_q.disable_turbo     <= dis_f;
      result_q.fault             <= fault_code;
    end
  end

  // The fault code never takes the unused encoding.
  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    fault_code != 2'd3) else $error("fault code out of range");

  // The step-up lock never exceeds the long hold-off.
  a_lock_range: assert property (@(posedge clk) disable iff (rst)
    lock <= tdpc_pkg::LOCK_LONG) else $error("step-up lock out of range");

  // A limiter that is off leaves no running deduction after the clear.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.loop_a && !lim_act |=> prop == 16'sd0 && integrator == 16'sd0)
    else $error("loop state not cleared");

endmodule

`default_nettype wire

>>> rtl/core/tdpc_ctrl.sv
// Controller state machine of the thermal derating PI controller.
// Sequences the datapath stages per item. Uses tdpc_pkg.
`default_nettype none

module tdpc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tdpc_pkg::cmd_t         cmd,
  input  wire tdpc_pkg::status_t status
);

  tdpc_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdpc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      tdpc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = tdpc_pkg::S_FLAGS;
        end
      end
      tdpc_pkg::S_FLAGS: begin
        cmd.flags  = 1'b1;
        state_next = status.gear ? tdpc_pkg::S_DIV : tdpc_pkg::S_LOOP_A;
      end
      tdpc_pkg::S_LOOP_A: begin
        cmd.loop_a = 1'b1;
        state_next = status.run ? tdpc_pkg::S_LOOP_B : tdpc_pkg::S_DIV;
      end
      tdpc_pkg::S_LOOP_B: begin
        cmd.loop_b = 1'b1;
        state_next = tdpc_pkg::S_LOOP_C;
      end
      tdpc_pkg::S_LOOP_C: begin
        cmd.loop_c = 1'b1;
        state_next = tdpc_pkg::S_LOOP_D;
      end
      tdpc_pkg::S_LOOP_D: begin
        cmd.loop_d = 1'b1;
        state_next = tdpc_pkg::S_DIV;
      end
      tdpc_pkg::S_DIV: begin
        cmd.div    = 1'b1;
        state_next = tdpc_pkg::S_LIMIT;
      end
      tdpc_pkg::S_LIMIT: begin
        cmd.limit  = 1'b1;
        state_next = tdpc_pkg::S_OUT;
      end
      tdpc_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = tdpc_pkg::S_IDLE;
        end
      end
      default: state_next = tdpc_pkg::S_IDLE;
    endcase
  end

  // An accepted item always starts with the flag stage.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == tdpc_pkg::S_FLAGS) else $error("bad start");

  // A computed limit is offered in the next cycle.
  a_offer: assert property (@(posedge clk) disable iff (rst)
    cmd.limit |=> out_valid) else $error("result not offered");

  // A waiting result is held until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

`default_nettype wire

>>> rtl/core/thermal_derating_pi_controller.sv
// Thermal derating PI controller. Each accepted item (a control tick or a
// gear change) yields exactly one result item. A tick with the loop running
// passes through the flag update, four loop stages, a divide stage and a
// limit stage before its result is offered; a tick with the loop idle skips
// the last three loop stages and a gear change skips all four. The controller
// sequences one item at a time through the shared datapath: the result state
// and the idle state follow, and the next item is taken only once the
// receiver has taken the result.
// Configuration writes are always ready and take effect on the next cycle.
// Depends on tdpc_pkg, tdpc_if, tdpc_ctrl and tdpc_datapath.
`default_nettype none

module thermal_derating_pi_controller (
  input  wire logic clk,
  input  wire logic rst,
  tdpc_in_if.sink   sample,
  tdpc_out_if.source result,
  tdpc_cfg_if.sink  cfg
);

  tdpc_pkg::cmd_t    cmd;
  tdpc_pkg::status_t status;

  assign cfg.ready = 1'b1;

  // Sequencer.
  tdpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath.
  tdpc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item_d    (sample.item),
    .result_q  (result.item),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data)
  );

endmodule

`default_nettype wire
